// File: src/lws_pkg.sv
// ----------------------------------------------------------------------------
// lws_pkg: shared types, constants and functions of the latency window block
// Sizes of the sorted cell row, the result word layout and the percentile
// index calculation used by the cells, the row and the top level.
// ----------------------------------------------------------------------------
package lws_pkg;

  // Window depth and field widths.
  localparam int unsigned W      = 256;
  localparam int unsigned SMP_W  = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned FILL_W = $clog2(W + 1);
  localparam int unsigned IDX_W  = $clog2(W);

  // Percentile slots, in result order.
  localparam int unsigned NPCT     = 4;
  localparam int unsigned PCT_P50  = 0;
  localparam int unsigned PCT_P95  = 1;
  localparam int unsigned PCT_P99  = 2;
  localparam int unsigned PCT_P999 = 3;

  // Cells are folded in groups before the final OR in the top level.
  localparam int unsigned GRP_SZ = 16;
  localparam int unsigned NGRP   = (W + GRP_SZ - 1) / GRP_SZ;

  // Fixed-point rank fractions, rounded up so that floor(k*n >> SCALE)
  // equals floor(num*n/den) for every fill level of the window.
  localparam int unsigned SCALE   = 32;
  localparam int unsigned RECIP_W = SCALE + 1;
  localparam logic [RECIP_W-1:0] K_P95  =
    RECIP_W'(((64'd95 << SCALE) + 64'd99) / 64'd100);
  localparam logic [RECIP_W-1:0] K_P99  =
    RECIP_W'(((64'd99 << SCALE) + 64'd99) / 64'd100);
  localparam logic [RECIP_W-1:0] K_P999 =
    RECIP_W'(((64'd999 << SCALE) + 64'd999) / 64'd1000);

  // Operation codes carried in tuser.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Result word layout.
  localparam int unsigned OUT_BITS = CNT_W + SUM_W + 2 * SMP_W + FILL_W + NPCT * SMP_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic             valid;
    logic             gt;
    logic [SMP_W-1:0] value;
    logic [IDX_W-1:0] age;
  } link_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic             ins;
    logic             clr;
    logic             full;
    logic [SMP_W-1:0] sample;
  } ctl_t;

  typedef logic [NPCT-1:0][SMP_W-1:0]            pct_vec_t;
  typedef logic [NPCT-1:0][IDX_W-1:0]            idx_vec_t;
  typedef logic [NGRP-1:0][NPCT-1:0][SMP_W-1:0]  grp_vec_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PICK = 3'b010,
    ST_FOLD = 3'b100
  } state_e;

  // Sorted index floor(k*n >> SCALE), clamped to n-1. Not meaningful for n = 0.
  function automatic logic [IDX_W-1:0] pct_idx(input logic [FILL_W-1:0]  n,
                                               input logic [RECIP_W-1:0] k);
    logic [FILL_W+RECIP_W-1:0] prod;
    logic [FILL_W-1:0]         q;
    logic [FILL_W-1:0]         lim;
    prod = {{RECIP_W{1'b0}}, n} * {{FILL_W{1'b0}}, k};
    q    = prod[SCALE +: FILL_W];
    lim  = n - FILL_W'(1);
    if (q > lim) begin
      q = lim;
    end
    return q[IDX_W-1:0];
  endfunction

endpackage

// File: src/lws_cell.sv
// ----------------------------------------------------------------------------
// lws_cell: one slot of the sorted sample row
// Holds one sample, its arrival age and a valid flag. On an insert it takes
// its own value, a neighbor's value or the new sample, so that the row drops
// the oldest entry and stays in ascending order.
// ----------------------------------------------------------------------------
module lws_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lws_pkg::ctl_t          ctl_i,
  input  lws_pkg::link_t         prv_i,
  input  lws_pkg::link_t         nxt_i,
  input  logic                   below_self_i,
  input  logic                   below_prev_i,
  input  logic [lws_pkg::IDX_W-1:0] cell_idx_i,
  input  lws_pkg::idx_vec_t      pick_idx_i,
  output lws_pkg::link_t         self_o,
  output logic                   victim_o,
  output lws_pkg::pct_vec_t      pick_o
);
  import lws_pkg::*;

  localparam logic [IDX_W-1:0] AGE_MAX = IDX_W'(W - 1);

  logic             valid_q, valid_d;
  logic [SMP_W-1:0] value_q, value_d;
  logic [IDX_W-1:0] age_q, age_d;
  logic             gt_own, gr_self, gr_prev;
  logic [SMP_W-1:0] r_self_val, r_prev_val;
  logic [IDX_W-1:0] r_self_age, r_prev_age;

  // Greater-than flag; an empty slot counts as greater than any sample.
  assign gt_own   = !valid_q || (value_q > ctl_i.sample);
  assign victim_o = ctl_i.full && (age_q == AGE_MAX);
  assign self_o   = '{valid: valid_q, gt: gt_own, value: value_q, age: age_q};

  // View of this slot and the one below after the oldest entry is removed.
  assign gr_self    = below_self_i ? nxt_i.gt    : gt_own;
  assign r_self_val = below_self_i ? nxt_i.value : value_q;
  assign r_self_age = below_self_i ? nxt_i.age   : age_q;
  assign gr_prev    = below_prev_i ? gt_own      : prv_i.gt;
  assign r_prev_val = below_prev_i ? value_q     : prv_i.value;
  assign r_prev_age = below_prev_i ? age_q       : prv_i.age;

  // Next contents of the slot.
  always_comb begin
    value_d = value_q;
    age_d   = age_q;
    valid_d = valid_q;
    if (ctl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctl_i.ins) begin
      valid_d = valid_q | prv_i.valid;
      if (!gr_self) begin
        value_d = r_self_val;
        age_d   = r_self_age + IDX_W'(1);
      end else if (!gr_prev) begin
        value_d = ctl_i.sample;
        age_d   = '0;
      end else begin
        value_d = r_prev_val;
        age_d   = r_prev_age + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

  // Offer the value to each percentile whose index points at this slot.
  always_comb begin
    for (int p = 0; p < NPCT; p++) begin
      pick_o[p] = (cell_idx_i == pick_idx_i[p]) ? value_q : '0;
    end
  end

endmodule

// File: src/lws_chain.sv
// ----------------------------------------------------------------------------
// lws_chain: the row of sorted sample cells
// Connects the cells to their neighbors, locates the entry that leaves the
// window with a prefix network over the victim flags, and folds the
// percentile picks of the cells into registered groups.
// ----------------------------------------------------------------------------
module lws_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lws_pkg::ctl_t       ctl_i,
  input  lws_pkg::idx_vec_t   pick_idx_i,
  input  logic                pick_en_i,
  output lws_pkg::grp_vec_t   grp_o
);
  import lws_pkg::*;

  localparam int unsigned LVL = $clog2(W);
  localparam link_t LINK_LOW  = '{valid: 1'b1, gt: 1'b0, value: '0, age: '0};
  localparam link_t LINK_HIGH = '{valid: 1'b0, gt: 1'b1, value: '0, age: '0};

  link_t     lnk [W];
  pct_vec_t  pick [W];
  logic [W-1:0] victim;
  logic [W-1:0] below;
  logic [W-1:0] valid_vec;
  logic [W-1:0] pre [LVL+1];
  grp_vec_t  grp_d, grp_q;

  // Prefix OR: below[i] is set when the evicted entry sits at or under slot i.
  assign pre[0] = victim;
  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    for (genvar i = 0; i < W; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
      end else begin : g_pass
        assign pre[l+1][i] = pre[l][i];
      end
    end
  end
  assign below = pre[LVL];

  // The row of cells.
  for (genvar i = 0; i < W; i++) begin : g_cell
    link_t prv, nxt;
    logic  below_prev;
    if (i == 0) begin : g_first
      assign prv        = LINK_LOW;
      assign below_prev = 1'b0;
    end else begin : g_mid
      assign prv        = lnk[i-1];
      assign below_prev = below[i-1];
    end
    if (i == W - 1) begin : g_last
      assign nxt = LINK_HIGH;
    end else begin : g_up
      assign nxt = lnk[i+1];
    end

    lws_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .prv_i       (prv),
      .nxt_i       (nxt),
      .below_self_i(below[i]),
      .below_prev_i(below_prev),
      .cell_idx_i  (IDX_W'(i)),
      .pick_idx_i  (pick_idx_i),
      .self_o      (lnk[i]),
      .victim_o    (victim[i]),
      .pick_o      (pick[i])
    );

    assign valid_vec[i] = lnk[i].valid;
  end

  // First fold stage: OR the picks of each group of cells.
  always_comb begin
    grp_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      for (int m = 0; m < GRP_SZ; m++) begin
        if (g * GRP_SZ + m < W) begin
          grp_d[g] = grp_d[g] | pick[g*GRP_SZ+m];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pick_en_i) begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

`ifndef SYNTHESIS
  // Ages stay distinct, so at most one cell can be the oldest.
  a_victim_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(victim))
    else $error("more than one cell flagged for eviction");

  // An insert into a full window always finds exactly one entry to drop.
  a_victim_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.ins && ctl_i.full) |-> $onehot(victim))
    else $error("full window without a single eviction candidate");

  // Occupied cells form a contiguous run from the bottom of the row.
  a_valid_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + W'(1))) == '0)
    else $error("occupied cells are not contiguous");
`endif

endmodule

// File: src/latency_window_statistics.sv
// ----------------------------------------------------------------------------
// latency_window_statistics: running and windowed latency statistics
// Each input transaction either records one latency sample in nanoseconds
// (tuser low) or clears all statistics and the window (tuser high), and
// produces one result transaction with the saturating count and sum, the
// minimum and maximum since the last clear, the window fill and the p50, p95,
// p99 and p99.9 values of the last 256 samples. The samples are kept in
// ascending order in a row of cells that drops the oldest entry and inserts
// the new one in the accepting cycle; the percentile read-out then captures
// per-group picks in the pick state and folds the groups into the output
// register in the fold state, which waits while a result is still held on
// the output. The next input transaction is taken only once the previous
// result is registered, while that result may still wait on the output.
// Percentiles read zero while the window is empty.
// ----------------------------------------------------------------------------
module latency_window_statistics (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // tdata: sample_ns[31:0]
  input  logic [31:0]               s_axis_tdata_i,
  // tuser: op[0]
  input  logic [0:0]                s_axis_tuser_i,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata: total_samples[31:0], latency_sum[79:32], latency_min[111:80],
  // latency_max[143:112], window_fill[152:144], p50[184:153], p95[216:185],
  // p99[248:217], p999[280:249], zero padding[287:281]
  output logic [lws_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i
);
  import lws_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SMP_W-1:0] min_q, min_d;
  logic [SMP_W-1:0] max_q, max_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  idx_vec_t         idx_q, idx_d;
  logic [OUT_W-1:0] out_q, out_d;
  logic             m_valid_q, m_valid_d;
  logic             accept, load, full;
  logic [SMP_W-1:0] sample;
  logic [SUM_W:0]   sum_ext;
  ctl_t             ctl;
  grp_vec_t         grp;
  pct_vec_t         pct;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign sample = s_axis_tdata_i;
  assign full   = (fill_q == FILL_W'(W));

  // Broadcast to the cell row.
  assign ctl = '{ins:    accept && (s_axis_tuser_i[0] == OP_RECORD),
                 clr:    accept && (s_axis_tuser_i[0] == OP_CLEAR),
                 full:   full,
                 sample: sample};

  lws_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .pick_idx_i(idx_q),
    .pick_en_i (state_q == ST_PICK),
    .grp_o     (grp)
  );

  // Running statistics, window fill and percentile indices for one transaction.
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sample);

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    min_d  = min_q;
    max_d  = max_q;
    fill_d = fill_q;
    if (ctl.clr) begin
      cnt_d  = '0;
      sum_d  = '0;
      min_d  = '1;
      max_d  = '0;
      fill_d = '0;
    end else if (ctl.ins) begin
      if (cnt_q != '1) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      if (sample < min_q) begin
        min_d = sample;
      end
      if (sample > max_q) begin
        max_d = sample;
      end
      if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
    idx_d[PCT_P50]  = fill_d[IDX_W:1];
    idx_d[PCT_P95]  = pct_idx(fill_d, K_P95);
    idx_d[PCT_P99]  = pct_idx(fill_d, K_P99);
    idx_d[PCT_P999] = pct_idx(fill_d, K_P999);
  end

  // Second fold stage: OR the group picks; an empty window reads zero.
  always_comb begin
    for (int p = 0; p < NPCT; p++) begin
      pct[p] = '0;
      for (int g = 0; g < NGRP; g++) begin
        pct[p] = pct[p] | grp[g][p];
      end
      if (fill_q == '0) begin
        pct[p] = '0;
      end
    end
  end

  assign out_d = {{(OUT_W - OUT_BITS){1'b0}}, pct[PCT_P999], pct[PCT_P99], pct[PCT_P95],
                  pct[PCT_P50], fill_q, max_q, min_q, sum_q, cnt_q};

  // Sequencer and output register handshake.
  assign load = (state_q == ST_FOLD) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
      sum_q     <= '0;
      min_q     <= '1;
      max_q     <= '0;
      fill_q    <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      min_q     <= min_d;
      max_q     <= max_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= idx_d;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  // The window never holds more entries than it has cells.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(W))
    else $error("window fill beyond window depth");

  // An accepted transaction always moves on to the pick cycle.
  a_accept_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_PICK))
    else $error("accepted transaction did not start the read-out");

  // The pick cycle is always followed by the fold cycle.
  a_pick_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK) |=> (state_q == ST_FOLD))
    else $error("read-out sequence broken");

  // Once a sample is recorded, the minimum never exceeds the maximum.
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("running minimum above running maximum");
`endif

endmodule
